[hw/rtl/fir3_pkg.sv]
// Shared types, constants and arithmetic helpers for the decimating FIR.
package fir3_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int QBITS       = 14;
  localparam int ACC_W       = 32;
  localparam int COEF_SLOTS  = 64;
  localparam int COEF_IDX_W  = 6;
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [15:0]         coef_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam acc_t ROUND_CONST = acc_t'(1 << (QBITS - 1));
  localparam acc_t SAT_MAX     = acc_t'(32767);
  localparam acc_t SAT_MIN     = -acc_t'(32768);

  // Symmetric Q14 low-pass taps; slots past the last tap are zero.
  localparam coef_t COEF_TABLE [COEF_SLOTS] = '{
    1: 16'sd29,    2: 16'sd42,    4: -16'sd95,   5: -16'sd140,
    7: 16'sd277,   8: 16'sd379,   10: -16'sd694, 11: -16'sd955,
    13: 16'sd2164, 14: 16'sd4461, 15: 16'sd5449, 16: 16'sd4461,
    17: 16'sd2164, 19: -16'sd955, 20: -16'sd694, 22: 16'sd379,
    23: 16'sd277,  25: -16'sd140, 26: -16'sd95,  28: 16'sd42,
    29: 16'sd29,   default: 16'sd0
  };

  // Queue entry: the sample and whether it closes a decimation group.
  typedef struct packed {
    sample_t sample;
    logic    emit;
  } job_t;

  typedef struct packed {
    logic busy;
    logic out_pending;
  } back_stat_t;

  function automatic sample_t sat16(input acc_t v);
    acc_t s;
    s = v >>> QBITS;
    if (s > SAT_MAX) begin
      return sample_t'(SAT_MAX);
    end else if (s < SAT_MIN) begin
      return sample_t'(SAT_MIN);
    end
    return sample_t'(s);
  endfunction

endpackage

[hw/rtl/fir3_if.sv]
// Stream interfaces for the input samples and the filtered results.
interface fir3_in_if
  import fir3_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fir3_out_if
  import fir3_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

[hw/rtl/fir3_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fir3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/fir3_queue.sv]
// Short job queue between the sample front end and the MAC back end.
module fir3_queue
  import fir3_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);

  job_t            slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_job;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/fir3_front.sv]
// Front end: takes input beats and tags the last sample of each group.
module fir3_front
  import fir3_pkg::*;
#(
  parameter int DECIMATION = 3
) (
  input  logic  clk,
  input  logic  rst,
  fir3_in_if.sink audio,
  input  logic  q_full,
  output logic  push,
  output job_t  push_job
);

  localparam int PHW = $clog2(DECIMATION);

  logic [PHW-1:0] phase;
  logic           group_end;

  assign group_end       = (phase == PHW'(DECIMATION - 1));
  // no beat is taken while reset is held
  assign audio.ready     = !q_full && !rst;
  assign push            = audio.valid && audio.ready;
  assign push_job.sample = audio.sample;
  assign push_job.emit   = group_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (push) begin
      phase <= group_end ? '0 : phase + 1'b1;
    end
  end

endmodule

[hw/rtl/fir3_back.sv]
// Back end: delay line write, shared multiply-accumulate over the taps, result register.
module fir3_back
  import fir3_pkg::*;
#(
  parameter int TAP_COUNT = 31
) (
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       q_empty,
  output logic       pop,
  output back_stat_t stat,
  fir3_out_if.source filtered
);

  localparam int TW = $clog2(TAP_COUNT);

  typedef enum logic [1:0] {
    B_IDLE,
    B_ISSUE,
    B_DRAIN
  } state_t;

  state_t                 state;
  logic [TW-1:0]          wp;
  logic [TW-1:0]          wp_inc;
  logic [TW-1:0]          idx;
  logic [TW-1:0]          idx_inc;
  logic [TW-1:0]          tap;
  logic [TAP_COUNT-1:0]   written;
  logic                   issue;

  // read stage: RAM data lands alongside these
  logic                   s1_vld;
  logic                   s1_last;
  logic                   s1_ok;
  logic [TW-1:0]          s1_tap;
  // product stage
  logic                   s2_vld;
  logic                   s2_last;
  acc_t                   prod;
  acc_t                   acc;
  acc_t                   acc_next;

  logic [SAMPLE_W-1:0]    rdata;
  sample_t                tap_data;
  coef_t                  tap_coef;
  logic                   out_vld;
  sample_t                out_sample;

  assign wp_inc   = (wp == TW'(TAP_COUNT - 1)) ? '0 : wp + 1'b1;
  assign idx_inc  = (idx == TW'(TAP_COUNT - 1)) ? '0 : idx + 1'b1;
  assign issue    = (state == B_ISSUE);
  assign pop      = (state == B_IDLE) && !q_empty && (!head.emit || !out_vld);
  assign tap_data = s1_ok ? sample_t'(rdata) : '0;
  assign tap_coef = COEF_TABLE[COEF_IDX_W'(s1_tap)];
  assign acc_next = acc + prod;

  assign filtered.valid      = out_vld;
  assign filtered.out_sample = out_sample;
  assign stat.busy           = (state != B_IDLE);
  assign stat.out_pending    = out_vld;

  fir3_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAP_COUNT)
  ) u_delay (
    .clk   (clk),
    .we    (pop),
    .waddr (wp),
    .wdata (head.sample),
    .re    (issue),
    .raddr (idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      wp      <= '0;
      written <= '0;
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      s1_vld <= issue;
      s2_vld <= s1_vld;
      if (filtered.ready && out_vld) begin
        out_vld <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            written[wp] <= 1'b1;
            wp          <= wp_inc;
            if (head.emit) begin
              // oldest sample meets the last tap
              idx   <= wp_inc;
              tap   <= TW'(TAP_COUNT - 1);
              acc   <= ROUND_CONST;
              state <= B_ISSUE;
            end
          end
        end
        B_ISSUE: begin
          idx <= idx_inc;
          tap <= tap - 1'b1;
          if (tap == '0) begin
            state <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (s2_vld && s2_last) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
      if (s2_vld) begin
        acc <= acc_next;
        if (s2_last) begin
          out_vld    <= 1'b1;
          out_sample <= sat16(acc_next);
        end
      end
    end
  end

  // payload pipeline, no reset needed
  always_ff @(posedge clk) begin
    s1_last <= (tap == '0);
    s1_tap  <= tap;
    s1_ok   <= written[idx];
    s2_last <= s1_last;
    prod    <= tap_data * tap_coef;
  end

endmodule

[hw/rtl/fir_decimator_by_three.sv]
// Top level: 31-tap low-pass FIR with decimation by three.
//
// Usage: samples enter on the audio channel, one signed 16-bit beat each,
// and filtered results leave on the filtered channel, one beat for every
// DECIMATION input beats. Both channels use valid/ready; a beat moves on a
// clock edge with both high.
// The front end tags each sample and pushes it into a four-entry queue;
// the back end writes it into the delay line RAM and, on the last sample
// of a group, runs one shared multiplier over all taps, one tap a cycle.
// A sample that closes no group is only written into the delay line; a
// group-closing sample is written, then its taps are issued and pass the
// read and product stages until its result sits in the output register.
// Input is accepted whenever the queue has room, also while a result waits.
// If the receiver stalls, the result is held and the next group's sum does
// not start until it is taken; samples keep queueing until the queue fills.
// Reset (synchronous, active high) clears the delay line to zero through
// per-slot valid bits, so no clearing pass is needed.
module fir_decimator_by_three
  import fir3_pkg::*;
#(
  parameter int TAP_COUNT  = 31,
  parameter int DECIMATION = 3
) (
  input  logic clk,
  input  logic rst,
  fir3_in_if.sink    audio,
  fir3_out_if.source filtered
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  job_t       push_job;
  job_t       head;
  back_stat_t stat;

  fir3_front #(
    .DECIMATION (DECIMATION)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .audio    (audio),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (push_job)
  );

  fir3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  fir3_back #(
    .TAP_COUNT (TAP_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (q_pop),
    .stat     (stat),
    .filtered (filtered)
  );

  // a sum is never in flight while an earlier result is still held
  a_busy_no_pending: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !stat.out_pending)
    else $error("accumulation running while result pending");

  // a result appears only as an accumulation finishes
  a_result_from_sum: assert property (@(posedge clk) disable iff (rst)
    $rose(filtered.valid) |-> $past(stat.busy) && !stat.busy)
    else $error("result without a completed sum");

  // the queue never takes a beat it has no room for
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("queue overflow");

  // nothing leaves an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !q_pop)
    else $error("queue underflow");

endmodule
